// ===== sv/nrp_pkg.sv =====
// Shared types and constants for the NDEF record parser.
`timescale 1ns / 1ps

package nrp_pkg;

    // Record header bits
    localparam logic [7:0] HDR_TNF_MASK = 8'h07;
    localparam logic [7:0] HDR_MB       = 8'h80;
    localparam logic [7:0] HDR_ME       = 8'h40;
    localparam logic [7:0] HDR_SR       = 8'h10;
    localparam logic [7:0] HDR_IL       = 8'h08;

    // Long payload length is four bytes
    localparam logic [31:0] PLEN_SHORT_BYTES = 32'd1;
    localparam logic [31:0] PLEN_LONG_BYTES  = 32'd4;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAX_RECORDS  = 8'd0;
    localparam logic [7:0] CFG_MAX_TYPE_LEN = 8'd1;

    localparam logic [7:0] MAX_RECORDS_RST  = 8'd8;
    localparam logic [7:0] MAX_TYPE_LEN_RST = 8'd32;

    // Result kinds
    localparam logic [1:0] KIND_TYPE = 2'd0;
    localparam logic [1:0] KIND_REC  = 2'd1;
    localparam logic [1:0] KIND_SUM  = 2'd2;

    // Summary status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;

    // Run queue between front and back
    localparam int RUN_DEPTH = 4;
    localparam int RUN_PTR_W = $clog2(RUN_DEPTH);
    localparam logic [RUN_PTR_W:0] RUN_DEPTH_C = (RUN_PTR_W + 1)'(RUN_DEPTH);

    typedef enum logic [3:0] {
        PH_HDR,
        PH_TLEN,
        PH_PLEN,
        PH_IDLEN,
        PH_TYPE,
        PH_ID,
        PH_PAYLOAD
    } t_phase;

    // All results caused by one input beat
    typedef struct packed {
        logic        emit_type;
        logic        emit_rec;
        logic        emit_sum;
        logic [7:0]  rec_idx;
        logic [7:0]  sum_idx;
        logic [7:0]  type_byte;
        logic [7:0]  type_idx;
        logic [7:0]  flags;
        logic [7:0]  type_len;
        logic [7:0]  id_len;
        logic [31:0] payload_len;
        logic [31:0] payload_offset;
        logic [1:0]  status;
    } t_run;

endpackage

// ===== sv/ndef_record_parser_unit.sv =====
// Top level of the NDEF record parser: front end, run queue, back end.
//
// Channel   Direction  Handshake              Beat
// input     in         push / full            data_byte, last, empty_message
// result    out        empty / pop            kind .. last_of_run (one result)
// config    in         i_cfg_we, no wait      i_cfg_addr, i_cfg_data
//
// One message byte is accepted per cycle while the run queue is not full; the
// front end parses it in that cycle and queues up to three results, which the
// back end sends one per cycle while pop is held. Results pass through the
// four-run queue and the back-end run register; a byte giving three results
// holds the output until all three are popped. full marks a full run queue.
// Reset is synchronous, active low, clears parser state, sets config defaults.
`timescale 1ns / 1ps

module ndef_record_parser_unit import nrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_empty_message,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_record_index,
    output logic [7:0]  o_type_byte,
    output logic [7:0]  o_type_index,
    output logic [7:0]  o_flags,
    output logic [2:0]  o_tnf,
    output logic [7:0]  o_type_len,
    output logic [7:0]  o_id_len,
    output logic [31:0] o_payload_len,
    output logic [31:0] o_payload_offset,
    output logic [1:0]  o_status,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    logic run_we, q_full, q_empty, q_rd;
    t_run run_in, run_out;

    assign full = q_full;

    nrp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (q_full),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .i_empty_message (i_empty_message),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_run_we        (run_we),
        .o_run           (run_in)
    );

    nrp_run_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (run_we),
        .i_wr_data (run_in),
        .o_full    (q_full),
        .i_rd_en   (q_rd),
        .o_rd_data (run_out),
        .o_empty   (q_empty)
    );

    nrp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_run            (run_out),
        .i_q_empty        (q_empty),
        .o_q_rd           (q_rd),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_kind           (o_kind),
        .o_record_index   (o_record_index),
        .o_type_byte      (o_type_byte),
        .o_type_index     (o_type_index),
        .o_flags          (o_flags),
        .o_tnf            (o_tnf),
        .o_type_len       (o_type_len),
        .o_id_len         (o_id_len),
        .o_payload_len    (o_payload_len),
        .o_payload_offset (o_payload_offset),
        .o_status         (o_status),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// ===== sv/nrp_front.sv =====
// Front end: accepts message bytes, tracks record parsing, builds result runs.
`timescale 1ns / 1ps

module nrp_front import nrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_q_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_empty_message,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    output logic        o_run_we,
    output t_run        o_run
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_position, n_position;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_hdr, n_hdr;
    logic [7:0]  r_tlen, n_tlen;
    logic [7:0]  r_idlen, n_idlen;
    logic [31:0] r_plen, n_plen;
    logic [31:0] r_pstart, n_pstart;
    logic [7:0]  r_tpos, n_tpos;
    logic [7:0]  r_recs, n_recs;
    logic        r_stopped, n_stopped;
    logic        r_trunc, n_trunc;
    logic [7:0]  r_max_recs;
    logic [7:0]  r_max_tlen;

    logic        accept;
    logic [31:0] pos1;
    logic        do_type, do_id, do_pay, do_cmp;
    t_run        run;

    assign accept = i_push && !i_q_full;
    assign pos1   = r_position + 32'd1;

    // Parser step for one byte, zero-length sections chained on the same beat
    always_comb begin
        n_phase   = r_phase;
        n_position = r_position;
        n_left    = r_left;
        n_hdr     = r_hdr;
        n_tlen    = r_tlen;
        n_idlen   = r_idlen;
        n_plen    = r_plen;
        n_pstart  = r_pstart;
        n_tpos    = r_tpos;
        n_recs    = r_recs;
        n_stopped = r_stopped;
        n_trunc   = r_trunc;
        do_type   = 1'b0;
        do_id     = 1'b0;
        do_pay    = 1'b0;
        do_cmp    = 1'b0;
        run       = '0;

        if (i_empty_message) begin
            run.emit_sum = 1'b1;
            run.status   = ST_NOT_FOUND;
            n_phase   = PH_HDR;
            n_position = '0;
            n_left    = '0;
            n_hdr     = '0;
            n_tlen    = '0;
            n_idlen   = '0;
            n_plen    = '0;
            n_pstart  = '0;
            n_tpos    = '0;
            n_recs    = '0;
            n_stopped = 1'b0;
            n_trunc   = 1'b0;
        end else begin
            n_position = pos1;
            if (!r_stopped) begin
                unique case (r_phase)
                    PH_HDR: begin
                        if (r_recs >= r_max_recs) begin
                            n_trunc   = 1'b1;
                            n_stopped = 1'b1;
                        end else begin
                            n_hdr   = i_data_byte;
                            n_phase = PH_TLEN;
                        end
                    end
                    PH_TLEN: begin
                        n_tlen  = i_data_byte;
                        n_idlen = '0;
                        n_plen  = '0;
                        n_left  = ((r_hdr & HDR_SR) != 8'd0) ? PLEN_SHORT_BYTES
                                                             : PLEN_LONG_BYTES;
                        n_phase = PH_PLEN;
                    end
                    PH_PLEN: begin
                        n_plen = {r_plen[23:0], i_data_byte};
                        n_left = r_left - 32'd1;
                        if (r_left == 32'd1) begin
                            if ((r_hdr & HDR_IL) != 8'd0) begin
                                n_phase = PH_IDLEN;
                            end else begin
                                do_type = 1'b1;
                            end
                        end
                    end
                    PH_IDLEN: begin
                        n_idlen = i_data_byte;
                        do_type = 1'b1;
                    end
                    PH_TYPE: begin
                        if (r_tpos < r_max_tlen) begin
                            run.emit_type = 1'b1;
                            run.type_byte = i_data_byte;
                            run.type_idx  = r_tpos;
                        end
                        n_tpos = r_tpos + 8'd1;
                        n_left = r_left - 32'd1;
                        do_id  = (r_left == 32'd1);
                    end
                    PH_ID: begin
                        n_left = r_left - 32'd1;
                        do_pay = (r_left == 32'd1);
                    end
                    PH_PAYLOAD: begin
                        n_left = r_left - 32'd1;
                        do_cmp = (r_left == 32'd1);
                    end
                    default: begin
                        n_phase = PH_HDR;
                    end
                endcase
            end

            // Section entry, skipping empty sections
            if (do_type) begin
                n_tpos   = '0;
                n_pstart = pos1 + {24'd0, n_tlen} + {24'd0, n_idlen};
                if (n_tlen != 8'd0) begin
                    n_phase = PH_TYPE;
                    n_left  = {24'd0, n_tlen};
                end else begin
                    do_id = 1'b1;
                end
            end
            if (do_id) begin
                if (n_idlen != 8'd0) begin
                    n_phase = PH_ID;
                    n_left  = {24'd0, n_idlen};
                end else begin
                    do_pay = 1'b1;
                end
            end
            if (do_pay) begin
                if (n_plen != 32'd0) begin
                    n_phase = PH_PAYLOAD;
                    n_left  = n_plen;
                end else begin
                    do_cmp = 1'b1;
                end
            end
            if (do_cmp) begin
                run.emit_rec = 1'b1;
                n_recs  = r_recs + 8'd1;
                n_phase = PH_HDR;
                if ((r_hdr & HDR_ME) != 8'd0) begin
                    n_stopped = 1'b1;
                end
            end

            // Record snapshot, shared by type and record beats
            run.rec_idx        = r_recs;
            run.flags          = n_hdr;
            run.type_len       = n_tlen;
            run.id_len         = n_idlen;
            run.payload_len    = n_plen;
            run.payload_offset = n_pstart;

            if (i_last) begin
                run.emit_sum = 1'b1;
                run.sum_idx  = n_recs;
                run.status   = n_trunc ? ST_TRUNC : ST_OK;
                n_phase   = PH_HDR;
                n_position = '0;
                n_left    = '0;
                n_hdr     = '0;
                n_tlen    = '0;
                n_idlen   = '0;
                n_plen    = '0;
                n_pstart  = '0;
                n_tpos    = '0;
                n_recs    = '0;
                n_stopped = 1'b0;
                n_trunc   = 1'b0;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_position <= '0;
            r_left     <= '0;
            r_hdr      <= '0;
            r_tlen     <= '0;
            r_idlen    <= '0;
            r_plen     <= '0;
            r_pstart   <= '0;
            r_tpos     <= '0;
            r_recs     <= '0;
            r_stopped  <= 1'b0;
            r_trunc    <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_left     <= n_left;
            r_hdr      <= n_hdr;
            r_tlen     <= n_tlen;
            r_idlen    <= n_idlen;
            r_plen     <= n_plen;
            r_pstart   <= n_pstart;
            r_tpos     <= n_tpos;
            r_recs     <= n_recs;
            r_stopped  <= n_stopped;
            r_trunc    <= n_trunc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_recs <= MAX_RECORDS_RST;
            r_max_tlen <= MAX_TYPE_LEN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_MAX_RECORDS) begin
                r_max_recs <= i_cfg_data;
            end
            if (i_cfg_addr == CFG_MAX_TYPE_LEN) begin
                r_max_tlen <= i_cfg_data;
            end
        end
    end

    // Beats with no result never enter the queue
    assign o_run_we = accept && (run.emit_type || run.emit_rec || run.emit_sum);
    assign o_run    = run;

endmodule

// ===== sv/nrp_run_fifo.sv =====
// Short queue of result runs between the front and back ends.
`timescale 1ns / 1ps

module nrp_run_fifo import nrp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    input  t_run   i_wr_data,
    output logic   o_full,
    input  logic   i_rd_en,
    output t_run   o_rd_data,
    output logic   o_empty
);

    t_run                 r_mem [RUN_DEPTH];
    logic [RUN_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [RUN_PTR_W:0]   r_count;
    logic                 wr, rd;

    assign o_full    = (r_count == RUN_DEPTH_C);
    assign o_empty   = (r_count == '0);
    assign wr        = i_wr_en && !o_full;
    assign rd        = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/nrp_back.sv =====
// Back end: unrolls queued runs into beats, one per cycle while pop is held.
`timescale 1ns / 1ps

module nrp_back import nrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_run        i_run,
    input  logic        i_q_empty,
    output logic        o_q_rd,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_record_index,
    output logic [7:0]  o_type_byte,
    output logic [7:0]  o_type_index,
    output logic [7:0]  o_flags,
    output logic [2:0]  o_tnf,
    output logic [7:0]  o_type_len,
    output logic [7:0]  o_id_len,
    output logic [31:0] o_payload_len,
    output logic [31:0] o_payload_offset,
    output logic [1:0]  o_status,
    output logic        o_last_of_run
);

    t_run       r_cur;
    logic       r_valid;
    logic [2:0] r_pend;   // {summary, record, type} still to send
    logic [2:0] rest;
    logic       take;
    logic       sel_type, sel_rec;

    assign rest     = r_pend & (r_pend - 3'd1);
    assign take     = r_valid && i_pop;
    assign o_q_rd   = !i_q_empty && (!r_valid || (take && (rest == 3'd0)));
    assign o_empty  = !r_valid;
    assign sel_type = r_pend[0];
    assign sel_rec  = !r_pend[0] && r_pend[1];

    // Current run and pending beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= '0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
            r_pend  <= {i_run.emit_sum, i_run.emit_rec, i_run.emit_type};
        end else if (take) begin
            r_pend  <= rest;
            r_valid <= (rest != 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_cur <= i_run;
        end
    end

    // Beat fields by kind
    always_comb begin
        o_kind           = KIND_SUM;
        o_record_index   = r_cur.sum_idx;
        o_type_byte      = '0;
        o_type_index     = '0;
        o_flags          = '0;
        o_tnf            = '0;
        o_type_len       = '0;
        o_id_len         = '0;
        o_payload_len    = '0;
        o_payload_offset = '0;
        o_status         = r_cur.status;
        if (sel_type || sel_rec) begin
            o_kind           = sel_type ? KIND_TYPE : KIND_REC;
            o_record_index   = r_cur.rec_idx;
            o_flags          = r_cur.flags;
            o_tnf            = r_cur.flags[2:0];
            o_type_len       = r_cur.type_len;
            o_id_len         = r_cur.id_len;
            o_payload_len    = r_cur.payload_len;
            o_payload_offset = r_cur.payload_offset;
            o_status         = ST_OK;
            if (sel_type) begin
                o_type_byte  = r_cur.type_byte;
                o_type_index = r_cur.type_idx;
            end
        end
    end

    assign o_last_of_run = (rest == 3'd0);

endmodule

// ===== sv/nrp_checker.sv =====
// Port-level checks for the NDEF record parser, bound to the top level.
`timescale 1ns / 1ps

module nrp_checker import nrp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_record_index,
    input logic [7:0]  o_flags,
    input logic [2:0]  o_tnf,
    input logic [1:0]  o_status,
    input logic        o_last_of_run
);

    // Output queue is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // A summary always closes its run
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_SUM) |-> o_last_of_run)
        else $error("summary not last of run");

    // Record beats carry TNF from the header and an ok status
    a_rec_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_TYPE || o_kind == KIND_REC))
        |-> (o_tnf == o_flags[2:0] && o_status == ST_OK))
        else $error("record beat fields inconsistent");

    // Not found always reports a zero count
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_SUM && o_status == ST_NOT_FOUND)
        |-> o_record_index == 8'd0)
        else $error("not found with nonzero count");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_record_index)))
        else $error("stalled result changed");

endmodule

bind ndef_record_parser_unit nrp_checker u_nrp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_record_index (o_record_index),
    .o_flags        (o_flags),
    .o_tnf          (o_tnf),
    .o_status       (o_status),
    .o_last_of_run  (o_last_of_run)
);
